>>> hw/rtl/lscg_pkg.sv
// Shared types and constants of the least-squares cell gradient block.
package lscg_pkg;

	localparam int MAX_FACES_DEF = 8;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DIFF_W        = 33;
	localparam int WIDE_W        = 128;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK,
		STAT_SINGULAR,
		STAT_ZERO_DIST,
		STAT_TOO_MANY
	} status_t;

	// One classified face word passed from the front to the back.
	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [DIFF_W-1:0] dv;
		logic                     acc;
		logic                     last;
		status_t                  stat;
	} cmd_t;

	// Back-end sequencer states.
	typedef enum logic [4:0] {
		B_IDLE,
		B_NORM,
		B_SQX,
		B_SQY,
		B_SQA,
		B_ROOT,
		B_UINIT,
		B_UDIV,
		B_TMUL,
		B_TACC,
		B_FIN,
		B_PMUL,
		B_PACC,
		B_PCOMMIT,
		B_CHECK,
		B_DIVX,
		B_DIVY,
		B_OUT
	} bstate_t;

	// Weighted sum terms, in the order they are accumulated.
	typedef enum logic [2:0] {
		T_XX,
		T_XY,
		T_YY,
		T_XV,
		T_YV
	} term_t;

endpackage

>>> hw/rtl/lscg_front.sv
// Front end: accepts face words, forms differences and classifies each face.
module lscg_front import lscg_pkg::*; #(
	parameter int MAX_FACES = MAX_FACES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] centre_x,
	input  logic signed [31:0] centre_y,
	input  logic signed [31:0] centre_value,
	input  logic signed [31:0] nbr_x,
	input  logic signed [31:0] nbr_y,
	input  logic signed [31:0] nbr_value,
	input  logic               last_face,
	input  logic               q_full,
	output logic               q_wr,
	output cmd_t               q_data
);

	localparam int FCW = $clog2(MAX_FACES + 1);

	logic [FCW-1:0] face_cnt_q;
	status_t        err_q;
	logic           too_many;
	logic           zero_dist;
	status_t        err_next;

	// Classification of the word on the input ports.
	always_comb begin
		too_many  = face_cnt_q >= FCW'(MAX_FACES);
		zero_dist = (nbr_x == centre_x) && (nbr_y == centre_y);
		if (err_q != STAT_OK) begin
			err_next = err_q;
		end else if (too_many) begin
			err_next = STAT_TOO_MANY;
		end else if (zero_dist) begin
			err_next = STAT_ZERO_DIST;
		end else begin
			err_next = STAT_OK;
		end
		q_wr        = push && !q_full;
		full        = q_full;
		q_data.dx   = {nbr_x[31], nbr_x} - {centre_x[31], centre_x};
		q_data.dy   = {nbr_y[31], nbr_y} - {centre_y[31], centre_y};
		q_data.dv   = {nbr_value[31], nbr_value} - {centre_value[31], centre_value};
		q_data.acc  = !too_many && !zero_dist;
		q_data.last = last_face;
		q_data.stat = err_next;
	end

	// Face count and first recorded error of the current cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_cnt_q <= '0;
			err_q      <= STAT_OK;
		end else if (q_wr) begin
			if (last_face) begin
				face_cnt_q <= '0;
				err_q      <= STAT_OK;
			end else begin
				if (!too_many) begin
					face_cnt_q <= face_cnt_q + FCW'(1);
				end
				err_q <= err_next;
			end
		end
	end

endmodule

>>> hw/rtl/lscg_queue.sv
// Two-entry queue of classified face words between the front and the back.
module lscg_queue import lscg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd,
	output cmd_t rd_data,
	output logic empty
);

	cmd_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign rd_data = mem_q[rp_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= !wp_q;
			end
			if (rd) begin
				rp_q <= !rp_q;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

>>> hw/rtl/lscg_wdiv.sv
// Unsigned restoring divider, one quotient bit per cycle.
module lscg_wdiv #(
	parameter int W = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quot
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          ge;

	// One restoring step.
	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	assign done = done_q;
	assign quot = quo_q;

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

endmodule

>>> hw/rtl/lscg_back.sv
// Back end: per-face direction and weighted sums, then the 2x2 solve.
module lscg_back import lscg_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  cmd_t        q_data,
	output logic        q_rd,
	input  logic        pop,
	output logic        empty,
	output logic [31:0] grad_x,
	output logic [31:0] grad_y,
	output logic [1:0]  status
);

	bstate_t st_q, st_n;

	logic signed [32:0] dx_q, dy_q, dv_q;
	logic               last_q;
	status_t            stat_q, res_stat_q;
	logic [32:0]        ax_q, ay_q, mx;
	logic [63:0]        s_q, r_q, bitv, rb;
	logic               root_ge;
	logic [4:0]         k_q, dc_q;
	logic [31:0]        d, rx_q, ry_q;
	logic [30:0]        qx_q, qy_q;
	logic [32:0]        tx, ty, txd, tyd;
	logic               gex, gey;
	term_t              t_q;
	logic signed [63:0] sxx_q, sxy_q, syy_q, sxv_q, syv_q;
	logic [32:0]        ta_mag;
	logic               ta_neg, tu_neg;
	logic [30:0]        tu_mag;
	logic [63:0]        term_m, delta;
	logic [2:0]         j_q;
	logic [1:0]         pk_q;
	logic signed [63:0] oa, ob;
	logic               osub, oneg;
	logic [1:0]         otgt;
	logic [63:0]        ma, mb;
	logic [31:0]        pa, pb;
	logic [127:0]       pp, pm_q, pm_s, det_q, nx_q, ny_q;
	logic [127:0]       det_mag, nx_mag, ny_mag, div_num, div_q;
	logic               det_zero, negx, negy, div_start, div_done;
	logic [32:0]        mul_a;
	logic [31:0]        mul_b;
	logic [64:0]        mul_q;
	logic [31:0]        gx_q, gy_q;
	logic               ovld_q;
	logic [31:0]        ogx_q, ogy_q;
	status_t            ost_q;
	logic               out_load;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		mag33 = v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		mag64 = v[63] ? 64'(-v) : 64'(v);
	endfunction

	// Truncated quotient to a signed 32-bit word with saturation.
	function automatic logic [31:0] sat32(input logic [127:0] q, input logic neg);
		logic [31:0] lim;
		logic        big;
		logic [31:0] m;
		lim    = neg ? 32'h8000_0000 : 32'h7fff_ffff;
		big    = (q[127:32] != '0) || (q[31:0] > lim);
		m      = big ? lim : q[31:0];
		sat32  = neg ? (32'd0 - m) : m;
	endfunction

	// Arithmetic helpers for the face loops.
	always_comb begin
		mx      = (ax_q > ay_q) ? ax_q : ay_q;
		bitv    = 64'(1) << {k_q, 1'b0};
		rb      = r_q + bitv;
		root_ge = s_q >= rb;
		d       = r_q[31:0];
		tx      = {rx_q, 1'b0};
		ty      = {ry_q, 1'b0};
		txd     = tx - {1'b0, d};
		tyd     = ty - {1'b0, d};
		gex     = tx >= {1'b0, d};
		gey     = ty >= {1'b0, d};
	end

	// Operands of the current weighted term.
	always_comb begin
		case (t_q)
			T_XX: begin
				ta_mag = mag33(dx_q); ta_neg = dx_q[32]; tu_mag = qx_q; tu_neg = dx_q[32];
			end
			T_XY: begin
				ta_mag = mag33(dx_q); ta_neg = dx_q[32]; tu_mag = qy_q; tu_neg = dy_q[32];
			end
			T_YY: begin
				ta_mag = mag33(dy_q); ta_neg = dy_q[32]; tu_mag = qy_q; tu_neg = dy_q[32];
			end
			T_XV: begin
				ta_mag = mag33(dv_q); ta_neg = dv_q[32]; tu_mag = qx_q; tu_neg = dx_q[32];
			end
			default: begin
				ta_mag = mag33(dv_q); ta_neg = dv_q[32]; tu_mag = qy_q; tu_neg = dy_q[32];
			end
		endcase
		term_m = 64'(mul_q[64:30]);
		delta  = (ta_neg ^ tu_neg) ? (64'd0 - term_m) : term_m;
	end

	// Operands of the current solve product; targets are det, nx and ny.
	always_comb begin
		case (j_q)
			3'd0: begin oa = sxx_q; ob = syy_q; osub = 1'b0; otgt = 2'd0; end
			3'd1: begin oa = sxy_q; ob = sxy_q; osub = 1'b1; otgt = 2'd0; end
			3'd2: begin oa = sxv_q; ob = syy_q; osub = 1'b0; otgt = 2'd1; end
			3'd3: begin oa = sxy_q; ob = syv_q; osub = 1'b1; otgt = 2'd1; end
			3'd4: begin oa = syv_q; ob = sxx_q; osub = 1'b0; otgt = 2'd2; end
			default: begin oa = sxy_q; ob = sxv_q; osub = 1'b1; otgt = 2'd2; end
		endcase
		ma   = mag64(oa);
		mb   = mag64(ob);
		oneg = oa[63] ^ ob[63] ^ osub;
		pa   = pk_q[1] ? ma[63:32] : ma[31:0];
		pb   = pk_q[0] ? mb[63:32] : mb[31:0];
		case (pk_q)
			2'd0:    pp = 128'(mul_q[63:0]);
			2'd3:    pp = 128'(mul_q[63:0]) << 64;
			default: pp = 128'(mul_q[63:0]) << 32;
		endcase
		pm_s     = oneg ? (128'd0 - pm_q) : pm_q;
		det_zero = det_q == '0;
		det_mag  = det_q[127] ? (128'd0 - det_q) : det_q;
		nx_mag   = nx_q[127] ? (128'd0 - nx_q) : nx_q;
		ny_mag   = ny_q[127] ? (128'd0 - ny_q) : ny_q;
		negx     = nx_q[127] ^ det_q[127];
		negy     = ny_q[127] ^ det_q[127];
		div_num  = ((st_q == B_DIVX) ? ny_mag : nx_mag) << FRAC_BITS;
	end

	// Control outputs of the sequencer.
	always_comb begin
		q_rd      = (st_q == B_IDLE) && !q_empty;
		out_load  = (st_q == B_OUT) && (!ovld_q || pop);
		div_start = ((st_q == B_CHECK) && !det_zero) || ((st_q == B_DIVX) && div_done);
		case (st_q)
			B_SQX: begin mul_a = ax_q; mul_b = ax_q[31:0]; end
			B_SQY: begin mul_a = ay_q; mul_b = ay_q[31:0]; end
			B_TMUL: begin mul_a = ta_mag; mul_b = {1'b0, tu_mag}; end
			B_PMUL: begin mul_a = {1'b0, pa}; mul_b = pb; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// Next state.
	always_comb begin
		st_n = st_q;
		case (st_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (q_data.acc) begin
						st_n = B_NORM;
					end else if (q_data.last) begin
						st_n = B_FIN;
					end
				end
			end
			B_NORM: begin
				if (mx[32:31] == 2'b00 && mx[30]) begin
					st_n = B_SQX;
				end
			end
			B_SQX:   st_n = B_SQY;
			B_SQY:   st_n = B_SQA;
			B_SQA:   st_n = B_ROOT;
			B_ROOT: begin
				if (k_q == 5'd0) begin
					st_n = B_UINIT;
				end
			end
			B_UINIT: st_n = B_UDIV;
			B_UDIV: begin
				if (dc_q == 5'd0) begin
					st_n = B_TMUL;
				end
			end
			B_TMUL:  st_n = B_TACC;
			B_TACC: begin
				if (t_q != T_YV) begin
					st_n = B_TMUL;
				end else if (last_q) begin
					st_n = B_FIN;
				end else begin
					st_n = B_IDLE;
				end
			end
			B_FIN:   st_n = (stat_q != STAT_OK) ? B_OUT : B_PMUL;
			B_PMUL:  st_n = B_PACC;
			B_PACC:  st_n = (pk_q == 2'd3) ? B_PCOMMIT : B_PMUL;
			B_PCOMMIT: st_n = (j_q == 3'd5) ? B_CHECK : B_PMUL;
			B_CHECK: st_n = det_zero ? B_OUT : B_DIVX;
			B_DIVX: begin
				if (div_done) begin
					st_n = B_DIVY;
				end
			end
			B_DIVY: begin
				if (div_done) begin
					st_n = B_OUT;
				end
			end
			B_OUT: begin
				if (out_load) begin
					st_n = B_IDLE;
				end
			end
			default: st_n = B_IDLE;
		endcase
	end

	// State, running sums and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= B_IDLE;
			ovld_q <= 1'b0;
			sxx_q  <= '0;
			sxy_q  <= '0;
			syy_q  <= '0;
			sxv_q  <= '0;
			syv_q  <= '0;
		end else begin
			st_q <= st_n;
			if (out_load) begin
				ovld_q <= 1'b1;
			end else if (pop) begin
				ovld_q <= 1'b0;
			end
			if (st_q == B_TACC) begin
				case (t_q)
					T_XX:    sxx_q <= sxx_q + $signed(delta);
					T_XY:    sxy_q <= sxy_q + $signed(delta);
					T_YY:    syy_q <= syy_q + $signed(delta);
					T_XV:    sxv_q <= sxv_q + $signed(delta);
					default: syv_q <= syv_q + $signed(delta);
				endcase
			end else if (out_load) begin
				sxx_q <= '0;
				sxy_q <= '0;
				syy_q <= '0;
				sxv_q <= '0;
				syv_q <= '0;
			end
		end
	end

	// Working registers of the face and solve loops.
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		case (st_q)
			B_IDLE: begin
				if (q_rd) begin
					dx_q   <= q_data.dx;
					dy_q   <= q_data.dy;
					dv_q   <= q_data.dv;
					last_q <= q_data.last;
					stat_q <= q_data.stat;
					ax_q   <= mag33(q_data.dx);
					ay_q   <= mag33(q_data.dy);
				end
			end
			B_NORM: begin
				if (mx[32:31] != 2'b00) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end else if (mx < 33'h0_0000_8000) begin
					ax_q <= ax_q << 16;
					ay_q <= ay_q << 16;
				end else if (mx < 33'h0_0080_0000) begin
					ax_q <= ax_q << 8;
					ay_q <= ay_q << 8;
				end else if (mx < 33'h0_0800_0000) begin
					ax_q <= ax_q << 4;
					ay_q <= ay_q << 4;
				end else if (mx < 33'h0_2000_0000) begin
					ax_q <= ax_q << 2;
					ay_q <= ay_q << 2;
				end else if (mx < 33'h0_4000_0000) begin
					ax_q <= ax_q << 1;
					ay_q <= ay_q << 1;
				end
			end
			B_SQY: s_q <= mul_q[63:0];
			B_SQA: begin
				s_q <= s_q + mul_q[63:0];
				r_q <= '0;
				k_q <= 5'd31;
			end
			B_ROOT: begin
				if (root_ge) begin
					s_q <= s_q - rb;
					r_q <= (r_q >> 1) + bitv;
				end else begin
					r_q <= r_q >> 1;
				end
				k_q <= k_q - 5'd1;
			end
			B_UINIT: begin
				qx_q <= {30'd0, ax_q >= {1'b0, d}};
				qy_q <= {30'd0, ay_q >= {1'b0, d}};
				rx_q <= (ax_q >= {1'b0, d}) ? 32'(ax_q - {1'b0, d}) : ax_q[31:0];
				ry_q <= (ay_q >= {1'b0, d}) ? 32'(ay_q - {1'b0, d}) : ay_q[31:0];
				dc_q <= 5'd29;
				t_q  <= T_XX;
			end
			B_UDIV: begin
				rx_q <= gex ? txd[31:0] : tx[31:0];
				ry_q <= gey ? tyd[31:0] : ty[31:0];
				qx_q <= {qx_q[29:0], gex};
				qy_q <= {qy_q[29:0], gey};
				dc_q <= dc_q - 5'd1;
			end
			B_TACC: begin
				case (t_q)
					T_XX:    t_q <= T_XY;
					T_XY:    t_q <= T_YY;
					T_YY:    t_q <= T_XV;
					T_XV:    t_q <= T_YV;
					default: t_q <= T_XX;
				endcase
			end
			B_FIN: begin
				j_q        <= 3'd0;
				pk_q       <= 2'd0;
				pm_q       <= '0;
				det_q      <= '0;
				nx_q       <= '0;
				ny_q       <= '0;
				gx_q       <= '0;
				gy_q       <= '0;
				res_stat_q <= stat_q;
			end
			B_PACC: begin
				pm_q <= pm_q + pp;
				pk_q <= pk_q + 2'd1;
			end
			B_PCOMMIT: begin
				case (otgt)
					2'd0:    det_q <= det_q + pm_s;
					2'd1:    nx_q  <= nx_q + pm_s;
					default: ny_q  <= ny_q + pm_s;
				endcase
				pm_q <= '0;
				pk_q <= 2'd0;
				j_q  <= j_q + 3'd1;
			end
			B_CHECK: begin
				if (det_zero) begin
					res_stat_q <= STAT_SINGULAR;
				end
			end
			B_DIVX: begin
				if (div_done) begin
					gx_q <= sat32(div_q, negx);
				end
			end
			B_DIVY: begin
				if (div_done) begin
					gy_q <= sat32(div_q, negy);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			ogx_q <= gx_q;
			ogy_q <= gy_q;
			ost_q <= res_stat_q;
		end
	end

	// Shared wide divider for both gradient components.
	lscg_wdiv #(
		.W (WIDE_W)
	) u_wdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (det_mag),
		.done   (div_done),
		.quot   (div_q)
	);

	assign empty  = !ovld_q;
	assign grad_x = ogx_q;
	assign grad_y = ogy_q;
	assign status = ost_q;

endmodule

>>> hw/rtl/least_squares_cell_gradient_2d.sv
// Top level of the weighted least-squares 2-D cell gradient block.
//
//   Channel   Direction  Handshake        Fields
//   face in   input      push / full      centre_x, centre_y, centre_value,
//                                         nbr_x, nbr_y, nbr_value, last_face
//   result    output     empty / pop      grad_x, grad_y, status
//
// An accumulated face passes the back end's 32-step square root and the 31-step
// direction divider; a skipped face is dropped from the queue. The last face of a
// cell then adds six 64x64 products on the shared 33x32 multiplier and two 128-step
// divisions in the wide divider; an error status skips both, a zero determinant the divisions.
// Reset clears the face count, the error record, the sums and the result valid flag.
// A two-word queue parts the front from the back, so faces are taken while a
// result waits; the back stalls only when a new result finds the last one untaken.
module least_squares_cell_gradient_2d import lscg_pkg::*; #(
	parameter int MAX_FACES = MAX_FACES_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] centre_x,
	input  logic signed [31:0] centre_y,
	input  logic signed [31:0] centre_value,
	input  logic signed [31:0] nbr_x,
	input  logic signed [31:0] nbr_y,
	input  logic signed [31:0] nbr_value,
	input  logic               last_face,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] grad_x,
	output logic signed [31:0] grad_y,
	output logic [1:0]         status
);

	logic q_wr, q_full, q_rd, q_empty;
	cmd_t q_wdata, q_rdata;

	// Front end: classification of incoming faces.
	lscg_front #(
		.MAX_FACES (MAX_FACES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.centre_x     (centre_x),
		.centre_y     (centre_y),
		.centre_value (centre_value),
		.nbr_x        (nbr_x),
		.nbr_y        (nbr_y),
		.nbr_value    (nbr_value),
		.last_face    (last_face),
		.q_full       (q_full),
		.q_wr         (q_wr),
		.q_data       (q_wdata)
	);

	// Queue between front and back.
	lscg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	// Back end: sums and solve.
	lscg_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.grad_x  (grad_x),
		.grad_y  (grad_y),
		.status  (status)
	);

	// A result with an error status carries a zero gradient.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != STAT_OK) |-> (grad_x == 32'sd0 && grad_y == 32'sd0))
		else $error("error result with nonzero gradient");

	// The front never writes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_full)
		else $error("queue written while full");

	// The back never reads an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_empty)
		else $error("queue read while empty");

endmodule

>>> tb/sv/testbench.sv
// Testbench for the weighted least-squares 2-D cell gradient block.
`timescale 1ns / 100ps

import lscg_pkg::*;

// Holds a model of the gradient sums and the queue of gradients still owed by the block.
class gradient_board;
	localparam int MAXF = MAX_FACES_DEF;
	localparam int FRAC = FRAC_BITS_DEF;

	typedef struct {
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		status_t            st;
	} grad_t;

	longint  s_xx, s_xy, s_yy, s_xv, s_yv;
	int      faces;
	status_t err_code;
	grad_t   owed[$];
	int      mismatches;
	int      seen[4];

	function void clear_sums();
		s_xx = 0; s_xy = 0; s_yy = 0; s_xv = 0; s_yv = 0;
		faces = 0;
		err_code = STAT_OK;
	endfunction

	function longint unsigned root64(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Signed product of a value and a unit component, truncated toward zero.
	function longint weigh(longint a, longint u);
		longint unsigned m;
		m = ((a < 0 ? -a : a) * (u < 0 ? -u : u)) >> 30;
		return ((a < 0) != (u < 0)) ? -longint'(m) : longint'(m);
	endfunction

	// Truncated quotient, scaled by the fraction bits and saturated to 32 bits.
	function logic signed [31:0] solve_part(logic signed [127:0] num, logic signed [127:0] den);
		logic [127:0] q, lim;
		bit neg;
		neg = (num < 0) != (den < 0);
		q = ((num < 0 ? -num : num) << FRAC) / (den < 0 ? -den : den);
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (q > lim) q = lim;
		return neg ? -q[31:0] : q[31:0];
	endfunction

	function new();
		clear_sums();
		mismatches = 0;
	endfunction

	// Notes one accepted face word and, on the last face, the gradient it owes.
	function void note_face(logic signed [31:0] cx, cy, cv, nx, ny, nv, bit last);
		longint dx, dy, dv, ux, uy;
		longint unsigned ax, ay, mx, d;
		logic signed [127:0] det, numx, numy, a, b, c, e, f;
		grad_t g;
		dx = longint'(nx) - longint'(cx);
		dy = longint'(ny) - longint'(cy);
		dv = longint'(nv) - longint'(cv);
		if (faces >= MAXF) begin
			if (err_code == STAT_OK) err_code = STAT_TOO_MANY;
		end else begin
			faces++;
			if (dx == 0 && dy == 0) begin
				if (err_code == STAT_OK) err_code = STAT_ZERO_DIST;
			end else begin
				ax = dx < 0 ? -dx : dx;
				ay = dy < 0 ? -dy : dy;
				mx = ax > ay ? ax : ay;
				while (mx >= 64'h8000_0000) begin ax >>= 1; ay >>= 1; mx >>= 1; end
				while (mx < 64'h4000_0000) begin ax <<= 1; ay <<= 1; mx <<= 1; end
				d = root64(ax * ax + ay * ay);
				ux = (ax << 30) / d;
				uy = (ay << 30) / d;
				if (dx < 0) ux = -ux;
				if (dy < 0) uy = -uy;
				s_xx += weigh(dx, ux);
				s_xy += weigh(dx, uy);
				s_yy += weigh(dy, uy);
				s_xv += weigh(dv, ux);
				s_yv += weigh(dv, uy);
			end
		end
		if (!last) return;
		g.gx = 0; g.gy = 0;
		if (err_code != STAT_OK) begin
			g.st = err_code;
		end else begin
			a = s_xx; b = s_yy; c = s_xy; e = s_xv; f = s_yv;
			det = a * b - c * c;
			if (det == 0) begin
				g.st = STAT_SINGULAR;
			end else begin
				numx = e * b - c * f;
				numy = f * a - c * e;
				g.gx = solve_part(numx, det);
				g.gy = solve_part(numy, det);
				g.st = STAT_OK;
			end
		end
		owed.push_back(g);
		clear_sums();
	endfunction

	// Compares one gradient word from the block with the oldest one owed.
	function void check_grad(logic signed [31:0] gx, gy, logic [1:0] st);
		grad_t g;
		if (owed.size() == 0) begin
			$error("Unexpected result word: grad_x %0d grad_y %0d status %0d", gx, gy, st);
			mismatches++;
			return;
		end
		g = owed.pop_front();
		seen[g.st]++;
		if (gx !== g.gx) begin
			$error("grad_x: expected %0d, actual %0d", g.gx, gx);
			mismatches++;
		end
		if (gy !== g.gy) begin
			$error("grad_y: expected %0d, actual %0d", g.gy, gy);
			mismatches++;
		end
		if (st !== g.st) begin
			$error("status: expected %0d, actual %0d", g.st, st);
			mismatches++;
		end
	endfunction
endclass

module testbench;
	localparam int HOLD_CYCLES = 3000;
	localparam int STALL_LIMIT = 20000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               pop = 1'b0;
	logic               full, empty;
	logic signed [31:0] centre_x = '0, centre_y = '0, centre_value = '0;
	logic signed [31:0] nbr_x = '0, nbr_y = '0, nbr_value = '0;
	logic               last_face = 1'b0;
	logic signed [31:0] grad_x, grad_y;
	logic [1:0]         status;

	gradient_board board = new();
	int  faces_sent = 0;
	int  cells_sent = 0;
	int  grads_taken = 0;
	int  idle_cycles = 0;
	bit  sending_done = 0;

	least_squares_cell_gradient_2d dut (.*);

	always #5 clk = ~clk;

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d cycles without a handshake", STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offers one face word after a random gap and waits until it is taken.
	task automatic send_face(logic signed [31:0] cx, cy, cv, nx, ny, nv, bit last);
		int gap;
		gap = $urandom_range(0, 18);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		centre_x <= cx; centre_y <= cy; centre_value <= cv;
		nbr_x <= nx; nbr_y <= ny; nbr_value <= nv;
		last_face <= last;
		push <= 1'b1;
		forever begin
			@(negedge clk);
			if (!full) break;
		end
		board.note_face(cx, cy, cv, nx, ny, nv, last);
		faces_sent++;
		if (last) cells_sent++;
		@(posedge clk);
	endtask

	// Sends a whole cell: nfaces neighbours round one centre, spread over span.
	task automatic send_cell(int nfaces, int span, bit line_only, int zero_pct);
		logic signed [31:0] cx, cy, cv, nx, ny, nv;
		cx = $urandom; cy = $urandom; cv = $urandom;
		if (span < 31) begin
			cx = $signed(cx) >>> 2; cy = $signed(cy) >>> 2; cv = $signed(cv) >>> 4;
		end
		for (int i = 0; i < nfaces; i++) begin
			if (span >= 31) begin
				nx = $urandom; ny = $urandom; nv = $urandom;
			end else begin
				nx = cx + ($signed($urandom) >>> (31 - span));
				ny = cy + ($signed($urandom) >>> (31 - span));
				nv = cv + ($signed($urandom) >>> (31 - span));
			end
			if (line_only) ny = cy;
			if ($urandom_range(0, 99) < zero_pct) begin
				nx = cx; ny = cy;
			end
			send_face(cx, cy, cv, nx, ny, nv, i == nfaces - 1);
		end
	endtask

	// Takes gradient words with random gaps, holding off once for a long stretch.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 18);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (grads_taken == 20) gap = HOLD_CYCLES;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			forever begin
				@(negedge clk);
				if (!empty) break;
			end
			board.check_grad(grad_x, grad_y, status);
			grads_taken++;
			@(posedge clk);
		end
	end

	// Stimulus: directed cells first, then random cells, then the final report.
	initial begin
		int n, span, wait_cycles;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opposite extremes of the coordinates and values.
		send_face(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
		send_face(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 0);
		send_face(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh0,
			32'sh8000_0000, 32'sh0, 32'sh7fff_ffff, 1);
		// A plain well-conditioned cell.
		send_face(0, 0, 0, 32'sh0001_0000, 0, 32'sh0002_0000, 0);
		send_face(0, 0, 0, 0, 32'sh0001_0000, 32'sh0003_0000, 0);
		send_face(0, 0, 0, 32'shffff_0000, 0, 32'shfffe_0000, 0);
		send_face(0, 0, 0, 0, 32'shffff_0000, 32'shfffd_0000, 1);
		// A zero-distance face.
		send_face(5, 7, 1, 9, 2, 3, 0);
		send_face(5, 7, 1, 5, 7, 3, 1);
		// A single face gives a singular system.
		send_face(1, 1, 1, 100, 1, 5, 1);
		// Faces on one line are singular too.
		send_cell(3, 20, 1, 0);
		// Too many faces.
		send_cell(10, 16, 0, 0);
		// Smallest nonzero distances.
		send_face(0, 0, 0, 1, 0, 32'sh7fff_ffff, 0);
		send_face(0, 0, 32'sh7fff_ffff, 0, 1, 32'sh8000_0000, 1);

		// Random cells: mostly well formed, some broken.
		while (faces_sent < 1750) begin
			n = $urandom_range(0, 9) == 0 ? $urandom_range(9, 12) : $urandom_range(2, 8);
			if ($urandom_range(0, 9) == 0) n = 1;
			case ($urandom_range(0, 9))
				0: span = 31;
				1: span = $urandom_range(1, 4);
				default: span = $urandom_range(8, 28);
			endcase
			send_cell(n, span, $urandom_range(0, 19) == 0,
				$urandom_range(0, 9) == 0 ? 30 : 0);
		end
		push <= 1'b0;

		wait (board.owed.size() == 0);
		wait_cycles = 0;
		while (wait_cycles < 600) begin
			@(posedge clk);
			wait_cycles++;
		end
		$display("Sent %0d face words in %0d cells and took %0d gradient words.",
			faces_sent, cells_sent, grads_taken);
		$display("Statuses: ok %0d, singular %0d, zero distance %0d, too many faces %0d.",
			board.seen[STAT_OK], board.seen[STAT_SINGULAR],
			board.seen[STAT_ZERO_DIST], board.seen[STAT_TOO_MANY]);
		if (board.mismatches == 0 && board.owed.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
